// File: design/cvg_pkg.sv
// Shared constants, types and tables for the cube-sphere vertex generator.
// Used by scoped name in every design file but cvg_if; depends on nothing.
package cvg_pkg;

    localparam int POINTS_PER_ROW = 64;
    localparam int GRID_SPAN      = (POINTS_PER_ROW > 1) ? POINTS_PER_ROW - 1 : 1;

    // Grid angle: round(a*|t|*PI_Q30 / ANGLE_DEN), split as a*|t|*QUO plus a
    // reciprocal-multiply of the small remainder term.
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned ANGLE_DEN   = 64'(180 * GRID_SPAN);
    localparam longint unsigned ANGLE_QUO   = PI_Q30 / ANGLE_DEN;
    localparam longint unsigned ANGLE_REM   = PI_Q30 % ANGLE_DEN;
    localparam int              RECIP_SHIFT = 38;
    localparam longint unsigned ANGLE_RECIP =
        ((64'd1 << RECIP_SHIFT) + ANGLE_DEN - 64'd1) / ANGLE_DEN;

    localparam logic [5:0] ANGLE_MAX   = 6'd45;
    localparam logic [5:0] ANGLE_RESET = 6'd30;

    localparam int                 CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    localparam logic [15:0] OUT_LIMIT   = 16'd16384;
    localparam int          QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        FACE_X    = 2'd0,
        FACE_Y    = 2'd1,
        FACE_Z    = 2'd2,
        FACE_NONE = 2'd3
    } face_t;

    typedef logic signed [31:0] angle_t;

    typedef struct packed {
        face_t  face;
        angle_t theta_a;
        angle_t theta_c;
        angle_t theta_r;
    } fe_item_t;

endpackage

// File: design/cvg_if.sv
// Channel interfaces of the cube-sphere vertex generator: input, result, config.
// Self-contained; no package needed.
interface cvg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] face;
    logic [5:0] row_index;
    logic [5:0] col_index;
    modport source (output valid, face, row_index, col_index, input ready);
    modport sink   (input valid, face, row_index, col_index, output ready);
endinterface

interface cvg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface cvg_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] inscription_angle;
    modport source (output valid, inscription_angle, input ready);
    modport sink   (input valid, inscription_angle, output ready);
endinterface

// File: design/cvg_queue.sv
// Short register queue between the front and back parts.
// Depends on cvg_pkg.
module cvg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  cvg_pkg::fe_item_t  push_item,
    output logic               push_ready,
    input  logic               pop,
    output cvg_pkg::fe_item_t  pop_item,
    output logic               empty
);

    localparam int PTR_W = $clog2(cvg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cvg_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(cvg_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cvg_pkg::QUEUE_DEPTH);

    cvg_pkg::fe_item_t mem_reg [cvg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign empty      = (cnt_reg == '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && !empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/cvg_front.sv
// Front part: accepts input beats, clamps indices, turns edge, column and
// row into Q30 angles over three stages. Depends on cvg_pkg, cvg_if.
module cvg_front (
    input  logic               clk,
    input  logic               rst_n,
    cvg_in_if.sink             in_ch,
    input  logic [5:0]         angle,
    input  logic               push_ready,
    output logic               push_valid,
    output cvg_pkg::fe_item_t  push_item
);

    localparam logic [7:0]  SPAN8   = 8'(cvg_pkg::GRID_SPAN);
    localparam logic [39:0] QUO40   = 40'(cvg_pkg::ANGLE_QUO);
    localparam logic [31:0] REM32   = 32'(cvg_pkg::ANGLE_REM);
    localparam logic [31:0] HALF32  = 32'(cvg_pkg::ANGLE_DEN / 2);
    localparam logic [31:0] RECIP32 = 32'(cvg_pkg::ANGLE_RECIP);

    logic               adv;
    logic               v1_reg, v2_reg, v3_reg;
    cvg_pkg::face_t     f1_reg, f2_reg, f3_reg;
    logic [13:0]        n1_reg     [3];
    logic               neg1_reg   [3];
    logic               neg2_reg   [3];
    logic               neg3_reg   [3];
    logic [39:0]        base2_reg  [3];
    logic [39:0]        base3_reg  [3];
    logic [31:0]        y2_reg     [3];
    logic [63:0]        prod3_reg  [3];
    logic [7:0]         kk         [3];
    logic signed [9:0]  tt         [3];
    logic [7:0]         mag        [3];
    logic               neg        [3];
    logic [63:0]        qq         [3];
    cvg_pkg::angle_t    theta      [3];

    assign adv         = !v3_reg || push_ready;
    assign in_ch.ready = adv;

    // Lane 0 is the patch edge angle, lane 1 the column, lane 2 the row.
    always_comb
    begin
        kk[0] = 8'd0;
        kk[1] = {2'b00, in_ch.col_index};
        kk[2] = {2'b00, in_ch.row_index};
        for (int l = 0; l < 3; l++)
        begin
            if (kk[l] > SPAN8)
            begin
                kk[l] = SPAN8;
            end
            tt[l]  = $signed({2'b00, SPAN8}) - $signed({1'b0, kk[l], 1'b0});
            neg[l] = tt[l][9];
            mag[l] = neg[l] ? 8'(-tt[l]) : 8'(tt[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= cvg_pkg::face_t'(in_ch.face);
            f2_reg <= f1_reg;
            f3_reg <= f2_reg;
            for (int l = 0; l < 3; l++)
            begin
                n1_reg[l]    <= {8'b0, angle} * {6'b0, mag[l]};
                neg1_reg[l]  <= neg[l];
                base2_reg[l] <= {26'b0, n1_reg[l]} * QUO40;
                y2_reg[l]    <= {18'b0, n1_reg[l]} * REM32 + HALF32;
                neg2_reg[l]  <= neg1_reg[l];
                prod3_reg[l] <= {32'b0, y2_reg[l]} * {32'b0, RECIP32};
                base3_reg[l] <= base2_reg[l];
                neg3_reg[l]  <= neg2_reg[l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            qq[l]    = {24'b0, base3_reg[l]} + (prod3_reg[l] >> cvg_pkg::RECIP_SHIFT);
            theta[l] = neg3_reg[l] ? -$signed(qq[l][31:0]) : $signed(qq[l][31:0]);
        end
    end

    assign push_valid        = v3_reg;
    assign push_item.face    = f3_reg;
    assign push_item.theta_a = theta[0];
    assign push_item.theta_c = theta[1];
    assign push_item.theta_r = theta[2];

endmodule

// File: design/cvg_back.sv
// Back part: CORDIC sin/cos, cross product, square root, radius scaling and
// per-coordinate division, one stage per step. Depends on cvg_pkg, cvg_if.
module cvg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cvg_pkg::fe_item_t  pop_item,
    input  logic               q_empty,
    output logic               pop,
    cvg_out_if.source          out_ch
);

    localparam int NCS        = cvg_pkg::CORDIC_STEPS;
    localparam int S_PROD     = NCS + 1;
    localparam int S_SQ       = S_PROD + 1;
    localparam int S_SUM      = S_SQ + 1;
    localparam int ROOT_STEPS = 32;
    localparam int S_ROOT_END = S_SUM + ROOT_STEPS;
    localparam int S_DEN      = S_ROOT_END + 1;
    localparam int S_NUM      = S_DEN + 1;
    localparam int DIV_STEPS  = 16;
    localparam int S_DIV_END  = S_NUM + DIV_STEPS;
    localparam int S_OUT      = S_DIV_END + 1;

    typedef struct packed {
        logic             blank;
        logic [2:0][31:0] vec;
        logic [31:0]      sc;
    } bk_carry_t;

    typedef struct packed {
        logic        zero;
        logic [2:0]  ovf;
        logic [2:0]  neg;
        logic [33:0] d;
    } bk_div_t;

    logic              adv;
    logic [S_OUT:0]    v_reg;

    logic signed [33:0] cx_reg [3][NCS+1];
    logic signed [33:0] cy_reg [3][NCS+1];
    logic signed [32:0] cz_reg [3][NCS+1];
    cvg_pkg::face_t     cf_reg [NCS+1];

    logic signed [31:0] c1, s1, c2, s2, pv, qv, rv;
    logic signed [63:0] m_cc, m_sc, m_cs;
    logic [2:0][31:0]   vec;
    logic signed [31:0] p_reg, q_reg, r_reg;
    logic signed [63:0] pp_reg, qq_reg, rr_reg;
    logic [63:0]        sq_reg;
    bk_carry_t          car_reg [S_PROD:S_DEN];

    logic [35:0]        rt_rem_reg  [ROOT_STEPS];
    logic [31:0]        rt_root_reg [ROOT_STEPS];
    logic [63:0]        rt_val_reg  [ROOT_STEPS];

    logic [63:0]        dprod;
    logic [33:0]        d_reg;

    logic signed [31:0] vl  [3];
    logic [31:0]        vm  [3];
    logic [46:0]        num [3];
    logic [33:0]        nm_rem_reg [3];
    logic [15:0]        nm_lo_reg  [3];
    bk_div_t            dc_reg [S_NUM:S_DIV_END];

    logic [33:0]        dv_rem_reg [DIV_STEPS][3];
    logic [15:0]        dv_q_reg   [DIV_STEPS][3];
    logic [15:0]        dv_lo_reg  [DIV_STEPS][3];

    logic [15:0]        qs   [3];
    logic signed [15:0] crd  [3];
    logic signed [15:0] x_reg, y_reg, z_reg;

    assign adv = !v_reg[S_OUT] || out_ch.ready;
    assign pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[S_OUT-1:0], pop};
        end
    end

    // Stage 0: load the three CORDIC lanes from the queue head.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cf_reg[0] <= pop_item.face;
            for (int l = 0; l < 3; l++)
            begin
                cx_reg[l][0] <= cvg_pkg::CORDIC_K;
                cy_reg[l][0] <= '0;
            end
            cz_reg[0][0] <= {pop_item.theta_a[31], pop_item.theta_a};
            cz_reg[1][0] <= {pop_item.theta_c[31], pop_item.theta_c};
            cz_reg[2][0] <= {pop_item.theta_r[31], pop_item.theta_r};
        end
    end

    for (genvar i = 0; i < NCS; i++)
    begin : g_cordic
        localparam logic signed [32:0] AT = $signed({1'b0, cvg_pkg::ATAN_Q30[i]});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cf_reg[i+1] <= cf_reg[i];
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!cz_reg[l][i][32])
                    begin
                        cx_reg[l][i+1] <= cx_reg[l][i] - (cy_reg[l][i] >>> i);
                        cy_reg[l][i+1] <= cy_reg[l][i] + (cx_reg[l][i] >>> i);
                        cz_reg[l][i+1] <= cz_reg[l][i] - AT;
                    end
                    else
                    begin
                        cx_reg[l][i+1] <= cx_reg[l][i] + (cy_reg[l][i] >>> i);
                        cy_reg[l][i+1] <= cy_reg[l][i] - (cx_reg[l][i] >>> i);
                        cz_reg[l][i+1] <= cz_reg[l][i] + AT;
                    end
                end
            end
        end
    end

    // Cross product of the two plane normals.
    assign c1   = cx_reg[1][NCS][31:0];
    assign s1   = cy_reg[1][NCS][31:0];
    assign c2   = cx_reg[2][NCS][31:0];
    assign s2   = cy_reg[2][NCS][31:0];
    assign m_cc = c1 * c2;
    assign m_sc = s1 * c2;
    assign m_cs = c1 * s2;
    assign pv   = m_cc[61:30];
    assign qv   = -$signed(m_sc[61:30]);
    assign rv   = -$signed(m_cs[61:30]);

    always_comb
    begin
        unique case (cf_reg[NCS])
            cvg_pkg::FACE_X:
            begin
                vec[0] = pv; vec[1] = qv; vec[2] = rv;
            end
            cvg_pkg::FACE_Y:
            begin
                vec[0] = rv; vec[1] = pv; vec[2] = qv;
            end
            cvg_pkg::FACE_Z:
            begin
                vec[0] = qv; vec[1] = rv; vec[2] = pv;
            end
            cvg_pkg::FACE_NONE:
            begin
                vec = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= pv;
            q_reg <= qv;
            r_reg <= rv;
            car_reg[S_PROD].blank <= (cf_reg[NCS] == cvg_pkg::FACE_NONE);
            car_reg[S_PROD].vec   <= vec;
            car_reg[S_PROD].sc    <= 32'(cx_reg[0][NCS] + cy_reg[0][NCS]);
            pp_reg <= p_reg * p_reg;
            qq_reg <= q_reg * q_reg;
            rr_reg <= r_reg * r_reg;
            sq_reg <= pp_reg + qq_reg + rr_reg;
            for (int s = S_PROD + 1; s <= S_DEN; s++)
            begin
                car_reg[s] <= car_reg[s-1];
            end
        end
    end

    // Digit-by-digit square root, two radicand bits per stage.
    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        logic [35:0] rin;
        logic [31:0] rtin;
        logic [63:0] vin;
        logic [35:0] remc;
        logic [35:0] trial;

        if (j == 0)
        begin : g_first
            assign rin  = '0;
            assign rtin = '0;
            assign vin  = sq_reg;
        end
        else
        begin : g_next
            assign rin  = rt_rem_reg[j-1];
            assign rtin = rt_root_reg[j-1];
            assign vin  = rt_val_reg[j-1];
        end

        assign remc  = {rin[33:0], vin[63:62]};
        assign trial = {2'b00, rtin, 2'b01};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (remc >= trial)
                begin
                    rt_rem_reg[j]  <= remc - trial;
                    rt_root_reg[j] <= {rtin[30:0], 1'b1};
                end
                else
                begin
                    rt_rem_reg[j]  <= remc;
                    rt_root_reg[j] <= {rtin[30:0], 1'b0};
                end
                rt_val_reg[j] <= {vin[61:0], 2'b00};
            end
        end
    end

    assign dprod = {32'b0, rt_root_reg[ROOT_STEPS-1]} * {32'b0, car_reg[S_ROOT_END].sc};

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            vl[l]  = $signed(car_reg[S_DEN].vec[l]);
            vm[l]  = vl[l][31] ? 32'(-vl[l]) : 32'(vl[l]);
            num[l] = {1'b0, vm[l], 14'b0} + {14'b0, d_reg[33:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= dprod[63:30];
            dc_reg[S_NUM].zero <= car_reg[S_DEN].blank || (d_reg == '0);
            dc_reg[S_NUM].d    <= d_reg;
            for (int l = 0; l < 3; l++)
            begin
                nm_rem_reg[l]        <= {3'b000, num[l][46:16]};
                nm_lo_reg[l]         <= num[l][15:0];
                dc_reg[S_NUM].ovf[l] <= ({3'b000, num[l][46:16]} >= d_reg);
                dc_reg[S_NUM].neg[l] <= vl[l][31];
            end
            for (int s = S_NUM + 1; s <= S_DIV_END; s++)
            begin
                dc_reg[s] <= dc_reg[s-1];
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [33:0] rin;
            logic [15:0] qin;
            logic [15:0] lin;
            logic [33:0] remc;

            if (k == 0)
            begin : g_first
                assign rin = nm_rem_reg[l];
                assign qin = '0;
                assign lin = nm_lo_reg[l];
            end
            else
            begin : g_next
                assign rin = dv_rem_reg[k-1][l];
                assign qin = dv_q_reg[k-1][l];
                assign lin = dv_lo_reg[k-1][l];
            end

            assign remc = {rin[32:0], lin[15]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (remc >= dc_reg[S_NUM+k].d)
                    begin
                        dv_rem_reg[k][l] <= remc - dc_reg[S_NUM+k].d;
                        dv_q_reg[k][l]   <= {qin[14:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k][l] <= remc;
                        dv_q_reg[k][l]   <= {qin[14:0], 1'b0};
                    end
                    dv_lo_reg[k][l] <= {lin[14:0], 1'b0};
                end
            end
        end
    end

    // Saturate, restore sign, drop results of the unused face code.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            qs[l] = dv_q_reg[DIV_STEPS-1][l];
            if (dc_reg[S_DIV_END].ovf[l] || (qs[l] > cvg_pkg::OUT_LIMIT))
            begin
                qs[l] = cvg_pkg::OUT_LIMIT;
            end
            crd[l] = dc_reg[S_DIV_END].neg[l] ? -$signed(qs[l]) : $signed(qs[l]);
            if (dc_reg[S_DIV_END].zero)
            begin
                crd[l] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= crd[0];
            y_reg <= crd[1];
            z_reg <= crd[2];
        end
    end

    assign out_ch.valid   = v_reg[S_OUT];
    assign out_ch.x_coord = x_reg;
    assign out_ch.y_coord = y_reg;
    assign out_ch.z_coord = z_reg;

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from an empty queue");

    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (x_reg <= 16'sd16384 && x_reg >= -16'sd16384 &&
                          y_reg <= 16'sd16384 && y_reg >= -16'sd16384 &&
                          z_reg <= 16'sd16384 && z_reg >= -16'sd16384))
        else $error("coordinate outside the saturation range");

endmodule

// File: design/cube_sphere_vertex_generator_unit.sv
// Top level of the cube-sphere vertex generator: config register, front part,
// queue and back part. Depends on cvg_pkg, cvg_if, cvg_front, cvg_queue, cvg_back.
//
//   channel  dir  payload                               beat moves
//   in_ch    in   face, row_index, col_index            one vertex request
//   out_ch   out  x_coord, y_coord, z_coord (Q2.14)     one vertex
//   cfg      in   inscription_angle                     new patch half span
//
// One beat per cycle is accepted and delivered while out_ch is not stalled.
// A beat passes through 3 front stages, the queue, 1 load stage, 24 CORDIC
// stages, 3 product stages, 32 square-root stages, 2 scaling stages,
// 16 division stages and 1 output stage.
// Reset clears all valid bits and loads an angle of 30 degrees.
// An output stall freezes the back pipeline; the front fills the four-entry
// queue and stalls in_ch once it is full and the last front stage holds a beat.
module cube_sphere_vertex_generator_unit (
    input  logic       clk,
    input  logic       rst_n,
    cvg_in_if.sink     in_ch,
    cvg_out_if.source  out_ch,
    cvg_cfg_if.sink    cfg
);

    logic [5:0]        angle_reg;
    logic [5:0]        angle_eff;
    logic              push_valid;
    logic              push_ready;
    cvg_pkg::fe_item_t push_item;
    logic              pop;
    logic              q_empty;
    cvg_pkg::fe_item_t pop_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= cvg_pkg::ANGLE_RESET;
        end
        else if (cfg.valid)
        begin
            angle_reg <= cfg.inscription_angle;
        end
    end

    // Hold the angle at its upper limit.
    assign angle_eff = (angle_reg > cvg_pkg::ANGLE_MAX) ? cvg_pkg::ANGLE_MAX : angle_reg;

    cvg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .angle      (angle_eff),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    cvg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_item   (pop_item),
        .empty      (q_empty)
    );

    cvg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_item (pop_item),
        .q_empty  (q_empty),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule
